### hw/rtl/hbbc_pkg.sv
package hbbc_pkg;

  localparam int NumBuffers = 32;
  localparam int NumBuckets = 13;
  localparam int IdxW = $clog2(NumBuffers);
  localparam int BktW = 4;

  localparam logic [2:0] KIND_GET     = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_PIN     = 3'd2;
  localparam logic [2:0] KIND_UNPIN   = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] granted_index;
    logic       needs_fill;
    logic       was_hit;
  } rsp_t;

  // one entry as seen by the scan unit
  typedef struct packed {
    logic [BktW-1:0] bucket;
    logic [7:0]      device;
    logic [31:0]     block;
    logic            free;
    logic [31:0]     last_free;
  } scan_ent_t;

  // scan unit result
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [NumBuckets-1:0] has_free;
    logic [NumBuckets-1:0][IdxW-1:0] free_idx;
  } scan_res_t;

endpackage

### hw/rtl/hashed_block_buffer_cache.sv
// Buffer cache tag table. One command at a time: start is taken while busy is
// low, and exactly one result strobe follows. Release, pin, unpin and tick
// strobe their result from S_SIMPLE, the state after the transfer, and a new
// command can be taken in the same cycle as that strobe. A get strobes from
// S_GRANT on a hit or when a free buffer is found, and from S_PICK when none
// is free after the victim search walks all 13 buckets: a digit-serial mod-13
// unit computes the bucket, the scan is launched, a one-entry-per-cycle scan
// walks the entries, its result is collected, then on a miss S_PICK steps
// through buckets from the home bucket. Results cannot be stalled.
module hashed_block_buffer_cache (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  hbbc_pkg::req_t req,
  output logic busy,
  output logic result_valid,
  output hbbc_pkg::rsp_t result
);
  localparam int N = hbbc_pkg::NumBuffers;
  localparam int IW = hbbc_pkg::IdxW;
  localparam int BW = hbbc_pkg::BktW;

  typedef enum logic [2:0] {S_IDLE, S_SIMPLE, S_MOD, S_SCAN, S_PICK, S_GRANT} state_t;
  state_t state;

  logic [7:0]  dev_m  [N];
  logic [31:0] blk_m  [N];
  logic [7:0]  refs   [N];
  logic [BW-1:0] bkt  [N];
  logic [N-1:0] loaded;
  logic [31:0] lastf  [N];
  logic [31:0] time_now;

  hbbc_pkg::req_t r;
  logic [BW-1:0] home, cur;
  logic [IW-1:0] pick;
  logic hit_r;

  logic mod_go, mod_done, scan_go, scan_done;
  logic [BW-1:0] rem;
  logic [IW-1:0] sidx;
  hbbc_pkg::scan_ent_t ent;
  hbbc_pkg::scan_res_t sres;

  assign busy = (state != S_IDLE);
  assign mod_go = start && !busy && req.kind == hbbc_pkg::KIND_GET;

  always_comb begin
    ent.bucket = bkt[sidx];
    ent.device = dev_m[sidx];
    ent.block = blk_m[sidx];
    ent.free = (refs[sidx] == 8'd0);
    ent.last_free = lastf[sidx];
  end

  hbbc_mod13 u_mod (.clk, .rst, .go(mod_go), .value(req.block_number),
    .done(mod_done), .rem);
  hbbc_scan u_scan (.clk, .rst, .go(scan_go), .home, .device(r.device),
    .block(r.block_number), .ent, .idx(sidx), .done(scan_done), .res(sres));

  assign scan_go = mod_done;

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      time_now <= '0;
      loaded <= '0;
      for (int i = 0; i < N; i++) begin
        dev_m[i] <= '0; blk_m[i] <= '0; refs[i] <= '0; bkt[i] <= '0; lastf[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (start) begin
          r <= req;
          state <= (req.kind == hbbc_pkg::KIND_GET) ? S_MOD : S_SIMPLE;
        end
        S_SIMPLE: begin
          result.granted_index <= '0;
          result.needs_fill <= 1'b0;
          result.was_hit <= 1'b0;
          result_valid <= 1'b1;
          state <= S_IDLE;
          case (r.kind)
            hbbc_pkg::KIND_PIN: begin
              if (refs[r.buffer_index] == 8'hFF) begin
                result.status <= hbbc_pkg::ST_RANGE;
              end else begin
                result.status <= hbbc_pkg::ST_OK;
                refs[r.buffer_index] <= refs[r.buffer_index] + 8'd1;
              end
            end
            hbbc_pkg::KIND_RELEASE, hbbc_pkg::KIND_UNPIN: begin
              if (refs[r.buffer_index] == 8'd0) begin
                result.status <= hbbc_pkg::ST_RANGE;
              end else begin
                result.status <= hbbc_pkg::ST_OK;
                refs[r.buffer_index] <= refs[r.buffer_index] - 8'd1;
                if (r.kind == hbbc_pkg::KIND_RELEASE && refs[r.buffer_index] == 8'd1)
                  lastf[r.buffer_index] <= time_now;
              end
            end
            hbbc_pkg::KIND_TICK: begin
              result.status <= hbbc_pkg::ST_OK;
              time_now <= time_now + 32'd1;
            end
            default: result.status <= hbbc_pkg::ST_OK;
          endcase
        end
        S_MOD: if (mod_done) begin
          home <= rem;
          state <= S_SCAN;
        end
        S_SCAN: if (scan_done) begin
          cur <= home;
          hit_r <= sres.hit;
          pick <= sres.hit_idx;
          state <= sres.hit ? S_GRANT : S_PICK;
        end
        S_PICK: begin
          if (sres.has_free[cur]) begin
            pick <= sres.free_idx[cur];
            state <= S_GRANT;
          end else if ((cur == BW'(hbbc_pkg::NumBuckets - 1) ? BW'(0) : cur + BW'(1))
                       == home) begin
            result <= '{hbbc_pkg::ST_NOFREE, 5'd0, 1'b0, 1'b0};
            result_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            cur <= (cur == BW'(hbbc_pkg::NumBuckets - 1)) ? BW'(0) : cur + BW'(1);
          end
        end
        S_GRANT: begin
          result_valid <= 1'b1;
          state <= S_IDLE;
          if (hit_r && refs[pick] == 8'hFF) begin
            result <= '{hbbc_pkg::ST_RANGE, 5'd0, 1'b0, 1'b0};
          end else begin
            result <= '{hbbc_pkg::ST_OK, 5'(pick), hit_r ? !loaded[pick] : 1'b1, hit_r};
            loaded[pick] <= 1'b1;
            if (hit_r) refs[pick] <= refs[pick] + 8'd1;
            else begin
              refs[pick] <= 8'd1;
              bkt[pick] <= home;
              dev_m[pick] <= r.device;
              blk_m[pick] <= r.block_number;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("strobe while busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> busy) else $error("scan while idle");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double result");
`endif
endmodule

### hw/rtl/hbbc_mod13.sv
// Block number mod 13, one 4-bit digit per cycle, MSB first.
module hbbc_mod13 (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] value,
  output logic        done,
  output logic [hbbc_pkg::BktW-1:0] rem
);
  logic [31:0] shreg;
  logic [3:0]  cnt;
  logic        run;
  logic [7:0]  acc;
  logic [7:0]  red;

  // acc < 16 * NumBuckets, so four compare-and-subtract steps reduce it
  always_comb begin
    acc = {rem, 4'b0} + {4'b0, shreg[31:28]};
    red = acc;
    if (red >= 8'(hbbc_pkg::NumBuckets * 8)) red = red - 8'(hbbc_pkg::NumBuckets * 8);
    if (red >= 8'(hbbc_pkg::NumBuckets * 4)) red = red - 8'(hbbc_pkg::NumBuckets * 4);
    if (red >= 8'(hbbc_pkg::NumBuckets * 2)) red = red - 8'(hbbc_pkg::NumBuckets * 2);
    if (red >= 8'(hbbc_pkg::NumBuckets)) red = red - 8'(hbbc_pkg::NumBuckets);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      rem <= '0;
    end else if (go) begin
      run <= 1'b1;
      cnt <= 4'd8;
      rem <= '0;
      shreg <= value;
    end else if (run) begin
      rem <= red[hbbc_pkg::BktW-1:0];
      shreg <= {shreg[27:0], 4'b0};
      cnt <= cnt - 4'd1;
      if (cnt == 4'd1) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### hw/rtl/hbbc_scan.sv
// Walks the entries one per cycle: first match in home bucket, and per bucket
// the oldest free entry (lowest index on ties).
module hbbc_scan (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [hbbc_pkg::BktW-1:0] home,
  input  logic [7:0]  device,
  input  logic [31:0] block,
  input  hbbc_pkg::scan_ent_t ent,
  output logic [hbbc_pkg::IdxW-1:0] idx,
  output logic done,
  output hbbc_pkg::scan_res_t res
);
  logic run;
  logic [hbbc_pkg::NumBuckets-1:0][31:0] best;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      idx <= '0;
    end else if (go) begin
      run <= 1'b1;
      idx <= '0;
      res.hit <= 1'b0;
      res.hit_idx <= '0;
      res.has_free <= '0;
      res.free_idx <= '0;
    end else if (run) begin
      if (ent.bucket == home && ent.device == device && ent.block == block
          && !res.hit) begin
        res.hit <= 1'b1;
        res.hit_idx <= idx;
      end
      // only the entry's own bucket can change
      if (ent.free && (!res.has_free[ent.bucket] || ent.last_free < best[ent.bucket]))
      begin
        res.has_free[ent.bucket] <= 1'b1;
        res.free_idx[ent.bucket] <= idx;
        best[ent.bucket] <= ent.last_free;
      end
      idx <= idx + hbbc_pkg::IdxW'(1);
      if (idx == hbbc_pkg::IdxW'(hbbc_pkg::NumBuffers - 1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  hbbc_pkg::req_t req = '0;
  logic busy;
  logic result_valid;
  hbbc_pkg::rsp_t result;

  hashed_block_buffer_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted cache contents
  logic [7:0]  tag_dev [hbbc_pkg::NumBuffers];
  logic [31:0] tag_blk [hbbc_pkg::NumBuffers];
  logic [7:0]  ref_cnt [hbbc_pkg::NumBuffers];
  logic [3:0]  tag_bkt [hbbc_pkg::NumBuffers];
  logic        loaded  [hbbc_pkg::NumBuffers];
  logic [31:0] freed_at[hbbc_pkg::NumBuffers];
  logic [31:0] clock_now;

  hbbc_pkg::rsp_t pending_rsp[$];
  int   n_errors = 0;
  int   n_results = 0;
  int   n_gets = 0, n_hits = 0, n_nofree = 0, n_range = 0;
  longint cycles = 0;
  logic [31:0] recent_blk[$];

  function automatic int oldest_free_in(logic [3:0] bkt);
    int pick;
    pick = -1;
    for (int i = 0; i < hbbc_pkg::NumBuffers; i++)
      if (tag_bkt[i] == bkt && ref_cnt[i] == 0)
        if (pick < 0 || freed_at[i] < freed_at[pick]) pick = i;
    return pick;
  endfunction

  function automatic hbbc_pkg::rsp_t cache_apply(hbbc_pkg::req_t r);
    hbbc_pkg::rsp_t o;
    int pick;
    logic [3:0] home, b;
    logic hit;
    o = '0;
    case (r.kind)
      hbbc_pkg::KIND_GET: begin
        home = 4'(r.block_number % hbbc_pkg::NumBuckets);
        pick = -1;
        hit = 1'b0;
        for (int i = 0; i < hbbc_pkg::NumBuffers; i++)
          if (!hit && tag_bkt[i] == home && tag_dev[i] == r.device &&
              tag_blk[i] == r.block_number) begin
            pick = i;
            hit = 1'b1;
          end
        if (hit) begin
          if (ref_cnt[pick] == 8'hff) begin
            o.status = hbbc_pkg::ST_RANGE;
            return o;
          end
          ref_cnt[pick]++;
        end else begin
          pick = oldest_free_in(home);
          b = 4'((home + 1) % hbbc_pkg::NumBuckets);
          while (pick < 0 && b != home) begin
            pick = oldest_free_in(b);
            b = 4'((b + 1) % hbbc_pkg::NumBuckets);
          end
          if (pick < 0) begin
            o.status = hbbc_pkg::ST_NOFREE;
            return o;
          end
          tag_bkt[pick] = home;
          tag_dev[pick] = r.device;
          tag_blk[pick] = r.block_number;
          loaded[pick] = 1'b0;
          ref_cnt[pick] = 8'd1;
        end
        o.status = hbbc_pkg::ST_OK;
        o.granted_index = 5'(pick);
        o.needs_fill = !loaded[pick];
        o.was_hit = hit;
        loaded[pick] = 1'b1;
      end
      hbbc_pkg::KIND_RELEASE, hbbc_pkg::KIND_PIN, hbbc_pkg::KIND_UNPIN: begin
        if (r.buffer_index >= hbbc_pkg::NumBuffers) o.status = hbbc_pkg::ST_RANGE;
        else if (r.kind == hbbc_pkg::KIND_PIN) begin
          if (ref_cnt[r.buffer_index] == 8'hff) o.status = hbbc_pkg::ST_RANGE;
          else ref_cnt[r.buffer_index]++;
        end else if (ref_cnt[r.buffer_index] == 0) o.status = hbbc_pkg::ST_RANGE;
        else begin
          ref_cnt[r.buffer_index]--;
          if (r.kind == hbbc_pkg::KIND_RELEASE && ref_cnt[r.buffer_index] == 0)
            freed_at[r.buffer_index] = clock_now;
        end
      end
      hbbc_pkg::KIND_TICK: clock_now = clock_now + 1;
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result checker: results cannot be held off
  always @(posedge clk) begin
    hbbc_pkg::rsp_t e;
    if (!rst && result_valid) begin
      n_results <= n_results + 1;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result %p", result);
        n_errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (result.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, result.status);
          n_errors++;
        end
        if (result.granted_index !== e.granted_index) begin
          $error("granted_index: expected %0d actual %0d", e.granted_index,
                 result.granted_index);
          n_errors++;
        end
        if (result.needs_fill !== e.needs_fill) begin
          $error("needs_fill: expected %0d actual %0d", e.needs_fill, result.needs_fill);
          n_errors++;
        end
        if (result.was_hit !== e.was_hit) begin
          $error("was_hit: expected %0d actual %0d", e.was_hit, result.was_hit);
          n_errors++;
        end
      end
    end
  end

  int burst_left = 0;

  // one transfer; random gaps between bursts
  task automatic send(input logic [2:0] k, input logic [7:0] dev,
                      input logic [31:0] blk, input logic [4:0] idx);
    hbbc_pkg::req_t r;
    hbbc_pkg::rsp_t e;
    int gap;
    r = '{kind: k, device: dev, block_number: blk, buffer_index: idx};
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    e = cache_apply(r);
    pending_rsp.push_back(e);
    if (k == hbbc_pkg::KIND_GET) begin
      n_gets++;
      if (e.was_hit) n_hits++;
    end
    if (e.status == hbbc_pkg::ST_NOFREE) n_nofree++;
    if (e.status == hbbc_pkg::ST_RANGE) n_range++;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send(hbbc_pkg::KIND_GET, 8'd0, 32'd0, 5'd0);           // reset entries: hit on entry 0
    send(hbbc_pkg::KIND_GET, 8'hff, 32'hffff_ffff, 5'd0);
    send(hbbc_pkg::KIND_RELEASE, 8'd0, 32'd0, 5'd0);
    send(hbbc_pkg::KIND_RELEASE, 8'd0, 32'd0, 5'd0);       // underflow
    send(hbbc_pkg::KIND_UNPIN, 8'd0, 32'd0, 5'd7);         // underflow
    send(hbbc_pkg::KIND_PIN, 8'd0, 32'd0, 5'd31);
    send(hbbc_pkg::KIND_UNPIN, 8'd0, 32'd0, 5'd31);
    send(hbbc_pkg::KIND_TICK, 8'd0, 32'd0, 5'd0);
    send(3'd5, 8'h55, 32'h5555_5555, 5'd21);
    send(3'd6, 8'haa, 32'haaaa_aaaa, 5'd10);
    send(3'd7, 8'h00, 32'h0, 5'd0);
    for (int i = 0; i < 256; i++)
      send(hbbc_pkg::KIND_PIN, 8'd0, 32'd0, 5'd3);  // overflow at end
    drain();
  endtask

  // fill every entry pinned, then more gets find no free buffer; then release all
  task automatic test_exhaust();
    for (int i = 0; i < 34; i++) send(hbbc_pkg::KIND_GET, 8'd1, 32'(i * 13 + 5), 5'd0);
    drain();
    for (int i = 0; i < hbbc_pkg::NumBuffers; i++) begin
      while (ref_cnt[i] != 0) send(hbbc_pkg::KIND_RELEASE, 8'd0, 32'd0, 5'(i));
      send(hbbc_pkg::KIND_TICK, 8'd0, 32'd0, 5'd0);
    end
    drain();
  endtask

  task automatic test_random(input int n);
    logic [2:0] k;
    logic [31:0] blk;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        if (recent_blk.size() != 0 && $urandom_range(0, 1))
          blk = recent_blk[$urandom_range(0, recent_blk.size() - 1)];
        else begin
          blk = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60);
          recent_blk.push_back(blk);
          if (recent_blk.size() > 24) void'(recent_blk.pop_front());
        end
        send(hbbc_pkg::KIND_GET,
             8'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1)),
             blk, 5'($urandom));
      end else begin
        if (p < 70) k = hbbc_pkg::KIND_RELEASE;
        else if (p < 78) k = hbbc_pkg::KIND_PIN;
        else if (p < 86) k = hbbc_pkg::KIND_UNPIN;
        else if (p < 97) k = hbbc_pkg::KIND_TICK;
        else k = 3'($urandom_range(5, 7));
        send(k, 8'($urandom), $urandom, 5'($urandom));
      end
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    clock_now = '0;
    for (int i = 0; i < hbbc_pkg::NumBuffers; i++) begin
      tag_dev[i] = '0; tag_blk[i] = '0; ref_cnt[i] = '0;
      tag_bkt[i] = '0; loaded[i] = 1'b0; freed_at[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_exhaust();
    test_random(730);
    repeat (100) @(posedge clk);
    $display("covered %0d results: %0d gets, %0d hits, %0d no-free, %0d range errors",
             n_results, n_gets, n_hits, n_nofree, n_range);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

### hashed_block_buffer_cache.f
hw/rtl/hbbc_pkg.sv
hw/rtl/hbbc_mod13.sv
hw/rtl/hbbc_scan.sv
hw/rtl/hashed_block_buffer_cache.sv
tb/testbench.sv
